// ===== sv/hcj_pkg.sv =====
// Shared types and constants of the HSV color jitter core.
package hcj_pkg;

   // Register indexes of the configuration port
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 16;
   typedef enum logic [CsrIdxW-1:0] {
      REG_HUE_SHIFT = 2'd0,
      REG_SAT_GAIN  = 2'd1,
      REG_EXP_GAIN  = 2'd2
   } reg_index_type;

   localparam int HueShiftW = 14;
   localparam int GainW = 16;

   // Divider: remainder/divisor width and quotient bits (Q.16 fraction)
   localparam int DivDenW = 11;
   localparam int QuotW = 16;
   localparam int DivStages = 4;

   // Saturation in Q.16, up to and including 1.0
   localparam int SatW = 17;
   localparam logic [SatW-1:0] SatOne = 17'h10000;

   // Accept to result strobe, in clock cycles
   localparam int Latency = 10;

   // Analysis side band, travels beside the divider
   typedef struct packed {
      logic       vld;
      logic       frame_end;
      logic [7:0] mx;
      logic       mx_zero;
      logic       d_zero;
      logic       d_full;
   } side_type;

   // HSV word handed from analysis to synthesis
   typedef struct packed {
      logic            vld;
      logic            frame_end;
      logic [7:0]      mx;
      logic [SatW-1:0] sat;
      logic [QuotW-1:0] hue;
   } hsv_type;

endpackage

// ===== sv/hcj_divider.sv =====
// Pipelined restoring divider: floor(num * 2^16 / den), num below den.
module hcj_divider #(
   parameter int DEN_W = hcj_pkg::DivDenW
) (
   input  logic                      clock,
   input  logic [DEN_W-1:0]          num,
   input  logic [DEN_W-1:0]          den,
   output logic [hcj_pkg::QuotW-1:0] quot
);

   localparam int Stages = hcj_pkg::DivStages;
   localparam int QW = hcj_pkg::QuotW;
   localparam int BitsPer = QW / Stages;

   logic [DEN_W-1:0] rem_ff  [Stages];
   logic [DEN_W-1:0] den_ff  [Stages];
   logic [QW-1:0]    quot_ff [Stages];
   logic [DEN_W-1:0] rem_in  [Stages];
   logic [DEN_W-1:0] den_in  [Stages];
   logic [QW-1:0]    quot_in [Stages];

   // A few quotient bits per stage
   always_comb begin
      logic [DEN_W-1:0] r;
      logic [DEN_W-1:0] dv;
      logic [QW-1:0]    q;
      logic [DEN_W:0]   trial;
      logic             ge;
      for (int s = 0; s < Stages; s++) begin
         if (s == 0) begin
            r  = num;
            dv = den;
            q  = '0;
         end else begin
            r  = rem_ff[s-1];
            dv = den_ff[s-1];
            q  = quot_ff[s-1];
         end
         for (int i = 0; i < BitsPer; i++) begin
            trial = {r, 1'b0};
            ge    = (trial >= {1'b0, dv});
            if (ge) begin
               trial = trial - {1'b0, dv};
            end
            q = {q[QW-2:0], ge};
            r = trial[DEN_W-1:0];
         end
         rem_in[s]  = r;
         den_in[s]  = dv;
         quot_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < Stages; s++) begin
         rem_ff[s]  <= rem_in[s];
         den_ff[s]  <= den_in[s];
         quot_ff[s] <= quot_in[s];
      end
   end

   assign quot = quot_ff[Stages-1];

endmodule

// ===== sv/hcj_analyze.sv =====
// RGB to HSV front end: max/min, hue numerator, two pipelined dividers.
module hcj_analyze (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [7:0]          red,
   input  logic [7:0]          green,
   input  logic [7:0]          blue,
   input  logic                frame_end,
   output hcj_pkg::hsv_type    hsv
);

   localparam int DW = hcj_pkg::DivDenW;
   localparam int Stages = hcj_pkg::DivStages;

   hcj_pkg::side_type side_in;
   hcj_pkg::side_type side_ff;
   hcj_pkg::side_type side_dly_ff [Stages];
   logic [DW-1:0] sat_num_in, sat_den_in, hue_num_in, hue_den_in;
   logic [DW-1:0] sat_num_ff, sat_den_ff, hue_num_ff, hue_den_ff;
   logic [hcj_pkg::QuotW-1:0] sat_q, hue_q;

   // Max, min, spread and hue numerator of one pixel
   always_comb begin
      logic [7:0]         mx, mn, d;
      logic [DW-1:0]      d6;
      logic signed [11:0] n;
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d  = mx - mn;
      d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
      if (red == mx) begin
         n = $signed({4'b0, green}) - $signed({4'b0, blue});
      end else if (green == mx) begin
         n = $signed({3'b0, d, 1'b0}) + $signed({4'b0, blue}) - $signed({4'b0, red});
      end else begin
         n = $signed({2'b0, d, 2'b0}) + $signed({4'b0, red}) - $signed({4'b0, green});
      end
      if (n < 0) begin
         n = n + $signed({1'b0, d6});
      end
      sat_num_in = {3'b0, d};
      sat_den_in = {3'b0, mx};
      hue_num_in = n[DW-1:0];
      hue_den_in = d6;
      side_in.vld       = in_vld;
      side_in.frame_end = frame_end;
      side_in.mx        = mx;
      side_in.mx_zero   = (mx == 8'd0);
      side_in.d_zero    = (d == 8'd0);
      side_in.d_full    = (d == mx) && (mx != 8'd0);
   end

   always_ff @(posedge clock) begin
      sat_num_ff <= sat_num_in;
      sat_den_ff <= sat_den_in;
      hue_num_ff <= hue_num_in;
      hue_den_ff <= hue_den_in;
      if (reset) begin
         side_ff.vld <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
   end

   hcj_divider #(.DEN_W(DW)) u_sat_div (
      .clock (clock),
      .num   (sat_num_ff),
      .den   (sat_den_ff),
      .quot  (sat_q)
   );

   hcj_divider #(.DEN_W(DW)) u_hue_div (
      .clock (clock),
      .num   (hue_num_ff),
      .den   (hue_den_ff),
      .quot  (hue_q)
   );

   // Side band follows the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) begin
            side_dly_ff[s].vld <= 1'b0;
         end
      end else begin
         side_dly_ff[0] <= side_ff;
         for (int s = 1; s < Stages; s++) begin
            side_dly_ff[s] <= side_dly_ff[s-1];
         end
      end
   end

   // Black pixels and full saturation bypass the saturation quotient; black and gray pixels bypass the hue quotient
   always_comb begin
      hsv.vld       = side_dly_ff[Stages-1].vld;
      hsv.frame_end = side_dly_ff[Stages-1].frame_end;
      hsv.mx        = side_dly_ff[Stages-1].mx;
      if (side_dly_ff[Stages-1].mx_zero) begin
         hsv.sat = '0;
      end else if (side_dly_ff[Stages-1].d_full) begin
         hsv.sat = hcj_pkg::SatOne;
      end else begin
         hsv.sat = {1'b0, sat_q};
      end
      hsv.hue = side_dly_ff[Stages-1].d_zero ? '0 : hue_q;
   end

endmodule

// ===== sv/hcj_synth.sv =====
// Gains, hue shift and HSV to RGB back end, five register stages.
module hcj_synth (
   input  logic                                clock,
   input  logic                                reset,
   input  hcj_pkg::hsv_type                    hsv,
   input  logic signed [hcj_pkg::HueShiftW-1:0] hue_shift,
   input  logic [hcj_pkg::GainW-1:0]           sat_gain,
   input  logic [hcj_pkg::GainW-1:0]           exp_gain,
   output logic                                out_vld,
   output logic [7:0]                          red,
   output logic [7:0]                          green,
   output logic [7:0]                          blue,
   output logic                                frame_end
);

   localparam logic signed [5:0] SectRedYellow  = 6'sd0;
   localparam logic signed [5:0] SectYellowGrn  = 6'sd1;
   localparam logic signed [5:0] SectGrnCyan    = 6'sd2;
   localparam logic signed [5:0] SectCyanBlue   = 6'sd3;
   localparam logic signed [5:0] SectBlueMag    = 6'sd4;
   localparam logic signed [21:0] XOne = 22'sd65536;

   // Stage A: gains and hue wrap
   logic               a_vld_ff, a_fe_ff;
   logic [20:0]        a_sq_ff, a_sq_in;
   logic [27:0]        a_vq_ff, a_vq_in;
   logic signed [18:0] a_hue_ff, a_hue_in;

   always_comb begin
      logic [32:0]        sp;
      logic [23:0]        vp;
      logic signed [19:0] hs16, hsum;
      sp = hsv.sat * sat_gain;
      vp = hsv.mx * exp_gain;
      a_sq_in = sp[32:12];
      a_vq_in = {vp, 4'b0};
      hs16 = {{2{hue_shift[13]}}, hue_shift, 4'b0};
      hsum = $signed({4'b0, hsv.hue}) + hs16;
      if (hsum > 20'sd65536) begin
         hsum = hsum - 20'sd65536;
      end
      if (hsum < 0) begin
         hsum = hsum + 20'sd65536;
      end
      a_hue_in = hsum[18:0];
   end

   always_ff @(posedge clock) begin
      a_vld_ff <= reset ? 1'b0 : hsv.vld;
      a_fe_ff  <= hsv.frame_end;
      a_sq_ff  <= a_sq_in;
      a_vq_ff  <= a_vq_in;
      a_hue_ff <= a_hue_in;
   end

   // Stage B: sector, fraction and the two fraction products
   logic              b_vld_ff, b_fe_ff;
   logic [20:0]       b_sq_ff;
   logic [27:0]       b_vq_ff;
   logic signed [5:0] b_sect_ff, b_sect_in;
   logic [20:0]       b_pq_ff, b_pq_in, b_pt_ff, b_pt_in;

   always_comb begin
      logic signed [21:0] h22, h6;
      logic [15:0]        f;
      logic [16:0]        fc;
      logic [36:0]        pq;
      logic [37:0]        pt;
      h22 = {{3{a_hue_ff[18]}}, a_hue_ff};
      h6  = (h22 <<< 2) + (h22 <<< 1);
      b_sect_in = h6[21:16];
      f  = h6[15:0];
      fc = 17'h10000 - {1'b0, f};
      pq = a_sq_ff * f;
      pt = a_sq_ff * fc;
      b_pq_in = pq[36:16];
      b_pt_in = pt[36:16];
   end

   always_ff @(posedge clock) begin
      b_vld_ff  <= reset ? 1'b0 : a_vld_ff;
      b_fe_ff   <= a_fe_ff;
      b_sq_ff   <= a_sq_ff;
      b_vq_ff   <= a_vq_ff;
      b_sect_ff <= b_sect_in;
      b_pq_ff   <= b_pq_in;
      b_pt_ff   <= b_pt_in;
   end

   // Stage C: per-channel factors by sector
   logic               c_vld_ff, c_fe_ff;
   logic [27:0]        c_vq_ff;
   logic signed [21:0] c_xr_ff, c_xg_ff, c_xb_ff, c_xr_in, c_xg_in, c_xb_in;

   always_comb begin
      logic signed [21:0] xp, xq, xt;
      xp = XOne - $signed({1'b0, b_sq_ff});
      xq = XOne - $signed({1'b0, b_pq_ff});
      xt = XOne - $signed({1'b0, b_pt_ff});
      if (b_sq_ff == '0) begin
         c_xr_in = XOne;
         c_xg_in = XOne;
         c_xb_in = XOne;
      end else begin
         case (b_sect_ff)
            SectRedYellow: begin
               c_xr_in = XOne; c_xg_in = xt; c_xb_in = xp;
            end
            SectYellowGrn: begin
               c_xr_in = xq; c_xg_in = XOne; c_xb_in = xp;
            end
            SectGrnCyan: begin
               c_xr_in = xp; c_xg_in = XOne; c_xb_in = xt;
            end
            SectCyanBlue: begin
               c_xr_in = xp; c_xg_in = xq; c_xb_in = XOne;
            end
            SectBlueMag: begin
               c_xr_in = xt; c_xg_in = xp; c_xb_in = XOne;
            end
            default: begin
               c_xr_in = XOne; c_xg_in = xp; c_xb_in = xq;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      c_vld_ff <= reset ? 1'b0 : b_vld_ff;
      c_fe_ff  <= b_fe_ff;
      c_vq_ff  <= b_vq_ff;
      c_xr_ff  <= c_xr_in;
      c_xg_ff  <= c_xg_in;
      c_xb_ff  <= c_xb_in;
   end

   // Stage D: value times factor, 32 fraction bits
   logic               d_vld_ff, d_fe_ff;
   logic signed [50:0] d_pr_ff, d_pg_ff, d_pb_ff;

   always_ff @(posedge clock) begin
      d_vld_ff <= reset ? 1'b0 : c_vld_ff;
      d_fe_ff  <= c_fe_ff;
      d_pr_ff  <= $signed({1'b0, c_vq_ff}) * c_xr_ff;
      d_pg_ff  <= $signed({1'b0, c_vq_ff}) * c_xg_ff;
      d_pb_ff  <= $signed({1'b0, c_vq_ff}) * c_xb_ff;
   end

   // Stage E: clamp to a byte
   function automatic logic [7:0] to_byte(input logic signed [50:0] p);
      logic [7:0] res;
      if (p[50] || (p == '0)) begin
         res = 8'd0;
      end else if (|p[49:40]) begin
         res = 8'd255;
      end else begin
         res = p[39:32];
      end
      return res;
   endfunction

   logic       e_vld_ff, e_fe_ff;
   logic [7:0] e_r_ff, e_g_ff, e_b_ff;

   always_ff @(posedge clock) begin
      e_vld_ff <= reset ? 1'b0 : d_vld_ff;
      e_fe_ff  <= d_fe_ff;
      e_r_ff   <= to_byte(d_pr_ff);
      e_g_ff   <= to_byte(d_pg_ff);
      e_b_ff   <= to_byte(d_pb_ff);
   end

   assign out_vld   = e_vld_ff;
   assign red       = e_r_ff;
   assign green     = e_g_ff;
   assign blue      = e_b_ff;
   assign frame_end = e_fe_ff;

endmodule

// ===== sv/hsv_color_jitter_core.sv =====
// HSV color jitter top level: configuration registers and pipeline.
// One pixel word is taken on every clock at which start is high; busy is
// never raised, so a pixel can follow in each cycle. Each result word shows
// on the rsp_ ports for one cycle with rsp_valid high; the receiver cannot
// hold results off. The path is one register stage of analysis, the
// four-stage saturation and hue dividers (four quotient bits per stage), and
// five stages of gain, sector select, multiply and clamp. Configuration
// writes take effect at once; the user must make them while no pixel is in
// flight, as the block does not enforce this.
module hsv_color_jitter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [7:0]                      req_red_in,
   input  logic [7:0]                      req_green_in,
   input  logic [7:0]                      req_blue_in,
   input  logic                            req_frame_end_in,
   input  logic                            csr_we,
   input  logic [hcj_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [hcj_pkg::CsrDataW-1:0]    csr_wdata,
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_red_out,
   output logic [7:0]                      rsp_green_out,
   output logic [7:0]                      rsp_blue_out,
   output logic                            rsp_frame_end_out
);

   logic signed [hcj_pkg::HueShiftW-1:0] hue_shift_ff;
   logic [hcj_pkg::GainW-1:0]            sat_gain_ff;
   logic [hcj_pkg::GainW-1:0]            exp_gain_ff;
   hcj_pkg::hsv_type                     hsv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_shift_ff <= '0;
         sat_gain_ff  <= 16'd4096;
         exp_gain_ff  <= 16'd4096;
      end else if (csr_we) begin
         case (csr_index)
            hcj_pkg::REG_HUE_SHIFT: hue_shift_ff <= csr_wdata[hcj_pkg::HueShiftW-1:0];
            hcj_pkg::REG_SAT_GAIN:  sat_gain_ff  <= csr_wdata;
            hcj_pkg::REG_EXP_GAIN:  exp_gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Fully pipelined, never stalls
   assign busy = 1'b0;

   hcj_analyze u_analyze (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (start && !busy),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .frame_end (req_frame_end_in),
      .hsv       (hsv)
   );

   hcj_synth u_synth (
      .clock     (clock),
      .reset     (reset),
      .hsv       (hsv),
      .hue_shift (hue_shift_ff),
      .sat_gain  (sat_gain_ff),
      .exp_gain  (exp_gain_ff),
      .out_vld   (rsp_valid),
      .red       (rsp_red_out),
      .green     (rsp_green_out),
      .blue      (rsp_blue_out),
      .frame_end (rsp_frame_end_out)
   );

   // Every accepted pixel gives a result word after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(hcj_pkg::Latency) rsp_valid)
      else $error("result word missing after pixel accept");

   // Frame end mark travels with its pixel
   a_frame_end : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(hcj_pkg::Latency)
         (rsp_frame_end_out == $past(req_frame_end_in, hcj_pkg::Latency)))
      else $error("frame end mark out of step");

   // Gray pixels stay gray
   a_gray : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_red_in == req_green_in && req_green_in == req_blue_in)
         |-> ##(hcj_pkg::Latency)
         (rsp_red_out == rsp_green_out && rsp_green_out == rsp_blue_out))
      else $error("gray pixel came out colored");

   // Black pixels stay black
   a_black : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_red_in == 8'd0 && req_green_in == 8'd0 && req_blue_in == 8'd0)
         |-> ##(hcj_pkg::Latency)
         (rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0))
      else $error("black pixel came out lit");

endmodule
